[rtl/core/rse_pkg.sv]
// Shared types and constants for the postfix stack evaluator.
package rse_pkg;

  localparam int DATA_W  = 64;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 5;
  localparam int COUNT_W = 16;
  localparam int STEP_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_DIVMOD = 3'd4,
    CMD_DROP   = 3'd5,
    CMD_SWAP   = 3'd6,
    CMD_END    = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_TOOMANY = 3'd4,
    ST_NOVALUE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_WAIT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_FIX
  } ustate_t;

  typedef struct packed {
    logic start;
    logic div;
  } md_req_t;

endpackage

[rtl/core/rse_if.sv]
// Valid/ready channels for the evaluator's operation words and result words.
interface rse_req_if;
  import rse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] literal;

  modport source(output valid, command, literal, input ready);
  modport sink(input valid, command, literal, output ready);
endinterface

interface rse_rsp_if;
  import rse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic                     finished;
  logic [COUNT_W-1:0]       item_count;

  modport source(output valid, status, top_value, depth, finished, item_count, input ready);
  modport sink(input valid, status, top_value, depth, finished, item_count, output ready);
endinterface

[rtl/core/rpn_stack_evaluator.sv]
// Postfix evaluator over 64-bit integers on a bounded operand stack.
// Push, end, a drop to empty, and a word that raises or meets an error go from decode straight to
// the result state. Drop, add, sub and swap on two or more values pass through a load state first;
// mul and divmod then wait on the 64 passes of the shared shift-add unit. One word is in flight at
// a time: a new word is taken once the result is registered, which waits while the sink stalls.
// Synchronous active-high reset empties the stack and clears the held error and the count.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  rse_req_if.sink  req,
  rse_rsp_if.source rsp
);
  import rse_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  state_t               state, state_next;
  logic [SP_W-1:0]      sp, sp_next;
  logic [DATA_W-1:0]    top, top_next;
  status_t              err, err_next;
  logic [COUNT_W-1:0]   items, items_next;
  cmd_t                 cmd, cmd_next;
  logic [DATA_W-1:0]    lit, lit_next;
  logic                 fin, fin_next;
  status_t              res_status, res_status_next;
  logic [COUNT_W-1:0]   res_count, res_count_next;

  logic                 o_valid, o_valid_next;
  logic [STAT_W-1:0]    o_status, o_status_next;
  logic [DATA_W-1:0]    o_top, o_top_next;
  logic [DEPTH_W-1:0]   o_depth, o_depth_next;
  logic                 o_fin, o_fin_next;
  logic [COUNT_W-1:0]   o_count, o_count_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;

  md_req_t              md_req;
  logic                 md_done;
  logic [DATA_W-1:0]    md_q, md_r;

  logic [SP_W-1:0]      sp_m1, sp_m2;
  logic [SP_W+4:0]      sp_ext;

  assign sp_m1  = sp - SP_W'(1);
  assign sp_m2  = sp - SP_W'(2);
  assign sp_ext = {5'b00000, sp};

  rse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rse_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .opa  (top),
    .opb  (ram_rdata),
    .done (md_done),
    .res_q(md_q),
    .res_r(md_r)
  );

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = o_valid;
  assign rsp.status     = o_status;
  assign rsp.top_value  = o_top;
  assign rsp.depth      = o_depth;
  assign rsp.finished   = o_fin;
  assign rsp.item_count = o_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      err     <= ST_OK;
      items   <= '0;
      fin     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      sp      <= sp_next;
      err     <= err_next;
      items   <= items_next;
      fin     <= fin_next;
      o_valid <= o_valid_next;
    end
    top        <= top_next;
    cmd        <= cmd_next;
    lit        <= lit_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    o_status   <= o_status_next;
    o_top      <= o_top_next;
    o_depth    <= o_depth_next;
    o_fin      <= o_fin_next;
    o_count    <= o_count_next;
  end

  always_comb begin
    state_next      = state;
    sp_next         = sp;
    top_next        = top;
    err_next        = err;
    items_next      = items;
    cmd_next        = cmd;
    lit_next        = lit;
    fin_next        = fin;
    res_status_next = res_status;
    res_count_next  = res_count;
    o_valid_next    = o_valid && !rsp.ready;
    o_status_next   = o_status;
    o_top_next      = o_top;
    o_depth_next    = o_depth;
    o_fin_next      = o_fin;
    o_count_next    = o_count;
    ram_we          = 1'b0;
    ram_waddr       = sp_m1[AW-1:0];
    ram_wdata       = top;
    ram_raddr       = sp_m2[AW-1:0];
    md_req.start    = 1'b0;
    md_req.div      = (cmd == CMD_DIVMOD);

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_next   = cmd_t'(req.command);
          lit_next   = req.literal;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_RESULT;
        if (cmd == CMD_END) begin
          fin_next        = 1'b1;
          res_count_next  = items;
          res_status_next = err;
          top_next        = '0;
          if (err == ST_OK) begin
            if (sp == SP_W'(1)) begin
              top_next = top;
            end else if (sp == '0) begin
              res_status_next = ST_NOVALUE;
            end else begin
              res_status_next = ST_TOOMANY;
            end
          end
          sp_next    = '0;
          err_next   = ST_OK;
          items_next = '0;
        end else begin
          fin_next = 1'b0;
          if (err == ST_OK) begin
            items_next = (items == '1) ? items : items + COUNT_W'(1);
            case (cmd)
              CMD_PUSH: begin
                if (sp == SP_W'(STACK_DEPTH)) begin
                  err_next = ST_FULL;
                end else begin
                  ram_we   = (sp != '0);
                  top_next = lit;
                  sp_next  = sp + SP_W'(1);
                end
              end
              CMD_DROP: begin
                if (sp == '0) begin
                  err_next = ST_UNDER;
                end else if (sp == SP_W'(1)) begin
                  sp_next = '0;
                end else begin
                  state_next = S_LOAD;
                end
              end
              default: begin
                if (sp < SP_W'(2)) begin
                  err_next = ST_UNDER;
                end else if (cmd == CMD_DIVMOD && top == '0) begin
                  err_next = ST_DIVZERO;
                end else begin
                  state_next = S_LOAD;
                end
              end
            endcase
          end
        end
      end

      S_LOAD: begin
        state_next = S_RESULT;
        case (cmd)
          CMD_DROP: begin
            top_next = ram_rdata;
            sp_next  = sp_m1;
          end
          CMD_ADD: begin
            top_next = ram_rdata + top;
            sp_next  = sp_m1;
          end
          CMD_SUB: begin
            top_next = ram_rdata - top;
            sp_next  = sp_m1;
          end
          CMD_SWAP: begin
            ram_we    = 1'b1;
            ram_waddr = sp_m2[AW-1:0];
            ram_wdata = top;
            top_next  = ram_rdata;
          end
          CMD_MUL, CMD_DIVMOD: begin
            md_req.start = 1'b1;
            state_next   = S_WAIT;
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end

      S_WAIT: begin
        if (md_done) begin
          state_next = S_RESULT;
          if (cmd == CMD_MUL) begin
            top_next = md_q;
            sp_next  = sp_m1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = sp_m2[AW-1:0];
            ram_wdata = md_q;
            top_next  = md_r;
          end
        end
      end

      S_RESULT: begin
        if (!o_valid || rsp.ready) begin
          o_valid_next  = 1'b1;
          o_fin_next    = fin;
          o_status_next = fin ? res_status : err;
          o_top_next    = (fin || sp != '0) ? top : '0;
          o_depth_next  = fin ? '0 : sp_ext[DEPTH_W-1:0];
          o_count_next  = fin ? res_count : items;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rse_muldiv.sv]
// Iterative shift-add multiplier and restoring signed divider on one shared adder.
module rse_muldiv (
  input  logic                     clk,
  input  logic                     rst,
  input  rse_pkg::md_req_t         req,
  input  logic [rse_pkg::DATA_W-1:0] opa,
  input  logic [rse_pkg::DATA_W-1:0] opb,
  output logic                     done,
  output logic [rse_pkg::DATA_W-1:0] res_q,
  output logic [rse_pkg::DATA_W-1:0] res_r
);
  import rse_pkg::*;

  ustate_t             state, state_next;
  logic [STEP_W-1:0]   cnt, cnt_next;
  logic [DATA_W-1:0]   acc, acc_next;
  logic [DATA_W-1:0]   x, x_next;
  logic [DATA_W-1:0]   y, y_next;
  logic                is_div, is_div_next;
  logic                neg_q, neg_q_next;
  logic                neg_r, neg_r_next;
  logic                done_next;
  logic [DATA_W-1:0]   q_next, r_next;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W+1:0]   op1, op2, sum;
  logic                nonneg;

  assign rem_sh = {acc, x[DATA_W-1]};
  assign op1    = is_div ? {1'b0, rem_sh} : {2'b00, acc};
  assign op2    = is_div ? ~{2'b00, y} : {2'b00, (y[0] ? x : '0)};
  assign sum    = op1 + op2 + {{(DATA_W+1){1'b0}}, is_div};
  assign nonneg = ~sum[DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    cnt    <= cnt_next;
    acc    <= acc_next;
    x      <= x_next;
    y      <= y_next;
    is_div <= is_div_next;
    neg_q  <= neg_q_next;
    neg_r  <= neg_r_next;
    res_q  <= q_next;
    res_r  <= r_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    acc_next    = acc;
    x_next      = x;
    y_next      = y;
    is_div_next = is_div;
    neg_q_next  = neg_q;
    neg_r_next  = neg_r;
    q_next      = res_q;
    r_next      = res_r;
    done_next   = 1'b0;
    case (state)
      U_IDLE: begin
        if (req.start) begin
          state_next  = U_RUN;
          cnt_next    = '0;
          acc_next    = '0;
          is_div_next = req.div;
          if (req.div) begin
            x_next     = opb[DATA_W-1] ? (~opb + 64'd1) : opb;
            y_next     = opa[DATA_W-1] ? (~opa + 64'd1) : opa;
            neg_q_next = opa[DATA_W-1] ^ opb[DATA_W-1];
            neg_r_next = opb[DATA_W-1];
          end else begin
            x_next     = opb;
            y_next     = opa;
            neg_q_next = 1'b0;
            neg_r_next = 1'b0;
          end
        end
      end
      U_RUN: begin
        cnt_next = cnt + STEP_W'(1);
        if (is_div) begin
          acc_next = nonneg ? sum[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          x_next   = {x[DATA_W-2:0], nonneg};
        end else begin
          acc_next = sum[DATA_W-1:0];
          x_next   = {x[DATA_W-2:0], 1'b0};
          y_next   = {1'b0, y[DATA_W-1:1]};
        end
        if (cnt == '1) begin
          state_next = U_FIX;
        end
      end
      U_FIX: begin
        if (is_div) begin
          q_next = neg_q ? (~x + 64'd1) : x;
          r_next = neg_r ? (~acc + 64'd1) : acc;
        end else begin
          q_next = acc;
          r_next = '0;
        end
        done_next  = 1'b1;
        state_next = U_IDLE;
      end
      default: begin
        state_next = U_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/rse_checker.sv]
// Port-level assertions for the postfix stack evaluator and their bind.
module rse_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [63:0] rsp_top_value,
  input logic [4:0]  rsp_depth,
  input logic        rsp_finished,
  input logic [15:0] rsp_item_count
);
  import rse_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_top_value) && $stable(rsp_depth) && $stable(rsp_finished) &&
      $stable(rsp_item_count))
    else $error("Result word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Operation word taken while the previous one is still in work.");

  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_finished |-> rsp_depth == '0)
    else $error("End result reports a nonempty stack.");

  a_end_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_finished && rsp_status != ST_OK |-> rsp_top_value == '0)
    else $error("End result with an error carries a nonzero value.");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_top_value (rsp.top_value),
  .rsp_depth     (rsp.depth),
  .rsp_finished  (rsp.finished),
  .rsp_item_count(rsp.item_count)
);

[dv/tb_rpn_stack_evaluator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the postfix stack evaluator with its own predictor.
module tb_rpn_stack_evaluator;
  import rse_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  value;
    logic [DEPTH_W-1:0] depth;
    logic               finished;
    logic [COUNT_W-1:0] count;
  } answer_t;

  logic clk;
  logic rst;

  rse_req_if req_ch();
  rse_rsp_if rsp_ch();

  rpn_stack_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [DATA_W-1:0] stk [STACK_DEPTH];
  int                stk_ptr = 0;
  status_t           held_err = ST_OK;
  int                op_count = 0;
  answer_t           answers_due [$];
  int                mismatches = 0;
  int                sent_words = 0;
  int                send_idle_max = 7;
  int                recv_idle_max = 7;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (mismatches < 100) begin
      $display("MISMATCH %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    end
    mismatches++;
  endtask

  function automatic status_t run_op(cmd_t c, logic [DATA_W-1:0] lit);
    logic [DATA_W-1:0] tos;
    logic [DATA_W-1:0] nos;
    if (c == CMD_PUSH) begin
      if (stk_ptr >= STACK_DEPTH) return ST_FULL;
      stk[stk_ptr] = lit;
      stk_ptr++;
      return ST_OK;
    end
    if (c == CMD_DROP) begin
      if (stk_ptr < 1) return ST_UNDER;
      stk_ptr--;
      return ST_OK;
    end
    if (stk_ptr < 2) return ST_UNDER;
    tos = stk[stk_ptr-1];
    nos = stk[stk_ptr-2];
    case (c)
      CMD_ADD: begin
        stk[stk_ptr-2] = nos + tos;
        stk_ptr--;
      end
      CMD_SUB: begin
        stk[stk_ptr-2] = nos - tos;
        stk_ptr--;
      end
      CMD_MUL: begin
        stk[stk_ptr-2] = nos * tos;
        stk_ptr--;
      end
      CMD_DIVMOD: begin
        if (tos == '0) return ST_DIVZERO;
        if (nos == VAL_MIN && tos == VAL_NEG1) begin
          stk[stk_ptr-2] = VAL_MIN;
          stk[stk_ptr-1] = '0;
        end else begin
          stk[stk_ptr-2] = $signed(nos) / $signed(tos);
          stk[stk_ptr-1] = $signed(nos) % $signed(tos);
        end
      end
      default: begin
        stk[stk_ptr-2] = tos;
        stk[stk_ptr-1] = nos;
      end
    endcase
    return ST_OK;
  endfunction

  function automatic void evaluate_op(cmd_t c, logic [DATA_W-1:0] lit);
    answer_t w;
    w = '0;
    if (c == CMD_END) begin
      w.status = held_err;
      if (held_err == ST_OK) begin
        if (stk_ptr == 1) w.value = stk[0];
        else if (stk_ptr > 1) w.status = ST_TOOMANY;
        else w.status = ST_NOVALUE;
      end
      w.finished = 1'b1;
      w.count = op_count[COUNT_W-1:0];
      stk_ptr = 0;
      held_err = ST_OK;
      op_count = 0;
    end else begin
      if (held_err == ST_OK) begin
        if (op_count < 65535) op_count++;
        held_err = run_op(c, lit);
      end
      w.status = held_err;
      w.value = (stk_ptr > 0) ? stk[stk_ptr-1] : '0;
      w.depth = stk_ptr[DEPTH_W-1:0];
      w.count = op_count[COUNT_W-1:0];
    end
    answers_due = {answers_due, w};
  endfunction

  function automatic logic [DATA_W-1:0] pick_literal();
    logic signed [DATA_W-1:0] near_zero;
    near_zero = DATA_W'($signed($urandom_range(0, 40)) - 20);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VAL_NEG1;
      2: return VAL_MIN;
      3: return VAL_MAX;
      4, 5: return near_zero;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(cmd_t c, logic [DATA_W-1:0] lit);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= c;
    req_ch.literal <= lit;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_words++;
    evaluate_op(c, lit);
  endtask

  task automatic test_arithmetic_wrap();
    send_word(CMD_PUSH, VAL_MAX);
    send_word(CMD_PUSH, 64'd1);
    send_word(CMD_ADD, VAL_NEG1);
    send_word(CMD_PUSH, VAL_NEG1);
    send_word(CMD_MUL, '0);
    send_word(CMD_PUSH, VAL_NEG1);
    send_word(CMD_DIVMOD, '0);
    send_word(CMD_DROP, '0);
    send_word(CMD_PUSH, 64'd5);
    send_word(CMD_SUB, '0);
    send_word(CMD_PUSH, -64'sd7);
    send_word(CMD_DIVMOD, '0);
    send_word(CMD_SWAP, '0);
    send_word(CMD_DROP, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic test_error_paths();
    send_word(CMD_ADD, '0);
    send_word(CMD_PUSH, 64'd1);
    send_word(CMD_END, '0);
    send_word(CMD_PUSH, 64'd4);
    send_word(CMD_PUSH, '0);
    send_word(CMD_DIVMOD, '0);
    send_word(CMD_END, '0);
    send_word(CMD_PUSH, 64'd1);
    send_word(CMD_PUSH, 64'd2);
    send_word(CMD_END, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic test_stack_full();
    int k;
    for (k = 0; k < STACK_DEPTH; k++) send_word(CMD_PUSH, pick_literal());
    send_word(CMD_PUSH, pick_literal());
    send_word(CMD_ADD, '0);
    send_word(CMD_END, '0);
  endtask

  task automatic run_program(int n_ops, int push_bias);
    int k;
    int pick;
    cmd_t c;
    for (k = 0; k < n_ops && held_err == ST_OK; k++) begin
      pick = $urandom_range(0, 9);
      if (stk_ptr < 2 || pick < push_bias) begin
        if (stk_ptr < STACK_DEPTH || $urandom_range(0, 3) == 0) c = CMD_PUSH;
        else c = CMD_SUB;
      end else begin
        c = cmd_t'($urandom_range(CMD_ADD, CMD_SWAP));
      end
      send_word(c, pick_literal());
    end
    if ($urandom_range(0, 3) != 0) begin
      while (held_err == ST_OK && stk_ptr > 1) begin
        send_word(cmd_t'($urandom_range(CMD_ADD, CMD_MUL)), pick_literal());
      end
    end
    send_word(CMD_END, pick_literal());
  endtask

  task automatic test_random_programs();
    int target;
    int k;
    int n;
    target = 450;
    while (sent_words < target) begin
      send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) send_word(cmd_t'($urandom_range(0, 7)), pick_literal());
      end else begin
        run_program($urandom_range(1, 24), $urandom_range(2, 8));
      end
    end
  endtask

  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, recv_idle_max);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result word", rsp_ch.top_value, '0);
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
        if (rsp_ch.top_value !== want.value)
          report_mismatch("top_value", rsp_ch.top_value, want.value);
        if (rsp_ch.depth !== want.depth)
          report_mismatch("depth", DATA_W'(rsp_ch.depth), DATA_W'(want.depth));
        if (rsp_ch.finished !== want.finished)
          report_mismatch("finished", DATA_W'(rsp_ch.finished), DATA_W'(want.finished));
        if (rsp_ch.item_count !== want.count)
          report_mismatch("item_count", DATA_W'(rsp_ch.item_count), DATA_W'(want.count));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_PUSH;
    req_ch.literal <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_arithmetic_wrap();
    test_error_paths();
    test_stack_full();
    test_random_programs();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
